[src/vbf_pkg.sv]
package vbf_pkg;

  localparam int unsigned DimMax       = 64;
  localparam int unsigned RadiusMax    = 3;
  localparam int unsigned VoxelBits    = 16;
  localparam int unsigned RangeEntries = 256;
  localparam int unsigned SpatialEntries = 3 * RadiusMax * RadiusMax + 1;

  localparam int unsigned CoordW  = $clog2(DimMax);
  localparam int unsigned SizeW   = CoordW + 1;
  localparam int unsigned AddrW   = 3 * CoordW;
  localparam int unsigned RadW    = 2;
  localparam int unsigned ScaleW  = 24;
  localparam int unsigned WIdxW   = 8;
  localparam int unsigned SpIdxW  = $clog2(SpatialEntries);
  localparam int unsigned WeightW = 16;
  localparam int unsigned DenW    = 26;
  localparam int unsigned SumW    = 42;
  localparam int unsigned QuoCnW  = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 24;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [SizeW-1:0]  size_t;
  typedef logic [AddrW-1:0]  vaddr_t;
  typedef logic [VoxelBits-1:0] voxel_t;
  typedef logic [WeightW-1:0] weight_t;

  typedef enum logic [1:0] {
    KindStore   = 2'd0,
    KindRange   = 2'd1,
    KindSpatial = 2'd2,
    KindFilter  = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRadius = 3'd0,
    CfgSizeX  = 3'd1,
    CfgSizeY  = 3'd2,
    CfgSizeZ  = 3'd3,
    CfgScale  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic   valid;
    logic   last;
    logic   is_center;
    logic [SpIdxW-1:0] d2;
  } nb_tag_t;

  typedef struct packed {
    logic start;
    logic [SumW-1:0] sum;
    logic [DenW-1:0] den;
    voxel_t center;
  } div_req_t;

endpackage

[src/vbf_divider.sv]
module vbf_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vbf_pkg::div_req_t   req_i,
  output logic                done_o,
  output vbf_pkg::voxel_t     quo_o,
  output logic                zero_o
);
  import vbf_pkg::*;

  logic              busy_q, busy_d;
  logic [QuoCnW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0]   num_q, num_d;
  logic [DenW:0]     rem_q, rem_d;
  logic [DenW-1:0]   den_q, den_d;
  voxel_t            ctr_q, ctr_d;
  logic              done_q, done_d;
  logic              zero_q, zero_d;
  voxel_t            quo_q, quo_d;
  logic [DenW:0]     trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    ctr_d  = ctr_q;
    done_d = 1'b0;
    zero_d = zero_q;
    quo_d  = quo_q;
    trial  = {rem_q[DenW-1:0], num_q[SumW-1]};
    if (req_i.start) begin
      num_d = req_i.sum;
      den_d = req_i.den;
      ctr_d = req_i.center;
      rem_d = '0;
      cnt_d = '0;
      if (req_i.den == '0) begin
        done_d = 1'b1;
        zero_d = 1'b1;
        quo_d  = req_i.center;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      num_d = {num_q[SumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = trial - {1'b0, den_q};
        num_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == QuoCnW'(SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        zero_d = 1'b0;
        quo_d  = num_d[VoxelBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    ctr_q  <= ctr_d;
    zero_q <= zero_d;
    quo_q  <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign zero_o = zero_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("divider restarted while busy");
  a_zero_ctr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && zero_q |-> quo_q == ctr_q) else $error("zero total lost center");

endmodule

[src/vbf_accum.sv]
module vbf_accum (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vbf_pkg::nb_tag_t      tag_i,
  input  vbf_pkg::voxel_t       vox_i,
  input  logic [vbf_pkg::ScaleW-1:0] scale_i,
  input  logic                  rng_we_i,
  input  logic                  sp_we_i,
  input  logic [vbf_pkg::WIdxW-1:0] widx_i,
  input  vbf_pkg::weight_t      wdata_i,
  output vbf_pkg::div_req_t     div_o
);
  import vbf_pkg::*;

  weight_t rng_mem [RangeEntries];
  weight_t sp_mem  [SpatialEntries];

  // stage 1: voxel data and center
  nb_tag_t t1_q;
  voxel_t  ctr_q, nv1_q;
  // stage 2: diff * scale
  nb_tag_t t2_q;
  voxel_t  nv2_q;
  logic [VoxelBits+ScaleW-1:0] prod_q;
  // stage 3: table reads
  nb_tag_t t3_q;
  voxel_t  nv3_q;
  weight_t rw_q, sw_q;
  // stage 4: weight
  nb_tag_t t4_q;
  voxel_t  nv4_q;
  logic [2*WeightW-1:0] wprod_q;
  // stage 5: w * nv
  nb_tag_t t5_q;
  logic [WeightW-1:0] w5_q;
  logic [WeightW+VoxelBits-1:0] wv_q;

  logic [SumW-1:0] sum_q;
  logic [DenW-1:0] den_q;
  voxel_t ctr5_q, ctr4_q, ctr3_q, ctr2_q;
  logic   start_q;

  voxel_t diff;
  logic [WIdxW-1:0] ri;

  assign diff = (ctr_q > nv1_q) ? ctr_q - nv1_q : nv1_q - ctr_q;
  assign ri   = (prod_q[VoxelBits+ScaleW-1:16] > (VoxelBits+ScaleW-16)'(255)) ? 8'hFF
              : prod_q[23:16];

  always_ff @(posedge clk_i) begin
    if (rng_we_i) rng_mem[widx_i] <= wdata_i;
    if (sp_we_i)  sp_mem[widx_i[SpIdxW-1:0]] <= wdata_i;
    rw_q <= rng_mem[ri];
    sw_q <= sp_mem[t2_q.d2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q    <= '0;
      t2_q    <= '0;
      t3_q    <= '0;
      t4_q    <= '0;
      t5_q    <= '0;
      start_q <= 1'b0;
    end else begin
      t1_q    <= tag_i;
      t2_q    <= t1_q;
      t3_q    <= t2_q;
      t4_q    <= t3_q;
      t5_q    <= t4_q;
      start_q <= t5_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    nv1_q <= vox_i;
    if (tag_i.valid && tag_i.is_center) ctr_q <= vox_i;
    nv2_q   <= nv1_q;
    ctr2_q  <= ctr_q;
    prod_q  <= diff * scale_i;
    nv3_q   <= nv2_q;
    ctr3_q  <= ctr2_q;
    nv4_q   <= nv3_q;
    ctr4_q  <= ctr3_q;
    wprod_q <= rw_q * sw_q;
    w5_q    <= wprod_q[2*WeightW-1:WeightW];
    wv_q    <= wprod_q[2*WeightW-1:WeightW] * nv4_q;
    ctr5_q  <= ctr4_q;
    if (t5_q.valid) begin
      if (t5_q.is_center) begin
        sum_q <= SumW'(wv_q);
        den_q <= DenW'(w5_q);
      end else begin
        sum_q <= sum_q + SumW'(wv_q);
        den_q <= den_q + DenW'(w5_q);
      end
    end
  end

  // the center is the first neighbor visited; it also resets the sums
  assign div_o.start  = start_q;
  assign div_o.sum    = sum_q;
  assign div_o.den    = den_q;
  assign div_o.center = ctr5_q;

  a_ctr_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t5_q.is_center |-> t5_q.valid) else $error("center tag without valid");
  a_start_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> !start_q) else $error("start held");
  a_ctr_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t5_q.valid && t5_q.last && !t5_q.is_center |-> $past(t5_q.valid))
    else $error("lone last tag");

endmodule

[src/volume_bilateral_filter_unit.sv]
// Filter unit over a 64x64x64 volume of 16-bit voxels. Store and weight-load
// commands do not raise busy. A filter command reads the center, then walks the
// cube of the configured radius one neighbor per cycle from the single voxel
// memory port (out-of-volume neighbors are visited too but carry no weight);
// the neighbors go through the weight pipeline into the weighted sums, and a
// radix-2 division of those sums gives the result. busy stays high through
// the result strobe; result_valid_o is high for one cycle and the result
// cannot be stalled. A filter at a position outside the configured size
// returns no result.
module volume_bilateral_filter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind_i,
  input  logic [vbf_pkg::CoordW-1:0]  pos_x_i,
  input  logic [vbf_pkg::CoordW-1:0]  pos_y_i,
  input  logic [vbf_pkg::CoordW-1:0]  pos_z_i,
  input  logic [vbf_pkg::WIdxW-1:0]   weight_index_i,
  input  logic [15:0]                 data_value_i,
  input  logic                        cfg_we_i,
  input  logic [vbf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [vbf_pkg::CfgW-1:0]    cfg_data_i,
  output logic                        result_valid_o,
  output logic [15:0]                 filtered_value_o,
  output logic                        zero_weight_o
);
  import vbf_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StWalk = 4'b0010,
    StWait = 4'b0100,
    StDiv  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [RadW-1:0]   radius_q;
  size_t             sx_q, sy_q, sz_q;
  logic [ScaleW-1:0] scale_q;

  voxel_t vox_mem [DimMax*DimMax*DimMax];
  voxel_t vox_rd_q;

  coord_t px_q, py_q, pz_q;
  logic [3:0] dx_q, dy_q, dz_q;  // offset + radius
  logic   ctr_pend_q;
  logic   accept;
  nb_tag_t tag;
  logic   rd_en;
  vaddr_t rd_addr;
  div_req_t div_req;
  logic   div_done;
  voxel_t quo;
  logic   zero;

  size_t sx, sy, sz;
  assign sx = (sx_q == '0) ? size_t'(1) : (sx_q > size_t'(DimMax)) ? size_t'(DimMax) : sx_q;
  assign sy = (sy_q == '0) ? size_t'(1) : (sy_q > size_t'(DimMax)) ? size_t'(DimMax) : sy_q;
  assign sz = (sz_q == '0) ? size_t'(1) : (sz_q > size_t'(DimMax)) ? size_t'(DimMax) : sz_q;

  logic signed [SizeW+1:0] nx, ny, nz;
  logic [3:0] r2;
  logic in_vol, last_off, ctr_off;
  logic [2:0] adx, ady, adz;

  assign r2 = {1'b0, radius_q, 1'b0};
  assign nx = $signed({2'b0, 1'b0, px_q}) + $signed({5'b0, dx_q}) - $signed({7'b0, radius_q});
  assign ny = $signed({2'b0, 1'b0, py_q}) + $signed({5'b0, dy_q}) - $signed({7'b0, radius_q});
  assign nz = $signed({2'b0, 1'b0, pz_q}) + $signed({5'b0, dz_q}) - $signed({7'b0, radius_q});
  assign in_vol = !nx[SizeW+1] && !ny[SizeW+1] && !nz[SizeW+1]
               && (nx[SizeW:0] < {1'b0, sx}) && (ny[SizeW:0] < {1'b0, sy})
               && (nz[SizeW:0] < {1'b0, sz});
  assign last_off = (dx_q == r2) && (dy_q == r2) && (dz_q == r2);
  assign ctr_off  = (dx_q == r2 / 2) && (dy_q == r2 / 2) && (dz_q == r2 / 2);
  assign adx = (dx_q >= r2 / 2) ? 3'(dx_q - {2'b0, radius_q}) : 3'({2'b0, radius_q} - dx_q);
  assign ady = (dy_q >= r2 / 2) ? 3'(dy_q - {2'b0, radius_q}) : 3'({2'b0, radius_q} - dy_q);
  assign adz = (dz_q >= r2 / 2) ? 3'(dz_q - {2'b0, radius_q}) : 3'({2'b0, radius_q} - dz_q);

  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    tag     = '0;
    rd_en   = 1'b0;
    rd_addr = {pz_q, py_q, px_q};
    unique case (state_q)
      StIdle: begin
        if (accept && kind_e'(kind_i) == KindFilter
            && {1'b0, pos_x_i} < sx && {1'b0, pos_y_i} < sy && {1'b0, pos_z_i} < sz) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        rd_en = 1'b1;
        if (ctr_pend_q) begin
          tag.valid     = 1'b1;
          tag.is_center = 1'b1;
          tag.d2        = '0;
        end else begin
          rd_addr   = {nz[CoordW-1:0], ny[CoordW-1:0], nx[CoordW-1:0]};
          tag.d2    = SpIdxW'(adx * adx + ady * ady + adz * adz);
          tag.last  = last_off;
          tag.valid = in_vol && !ctr_off;
          if (last_off) state_d = StDiv;
        end
      end
      StWait: state_d = StDiv;
      StDiv: begin
        if (div_done) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  nb_tag_t tag_d1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_d1_q <= '0;
    end else begin
      tag_d1_q <= tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && kind_e'(kind_i) == KindStore) begin
      vox_mem[{pos_z_i, pos_y_i, pos_x_i}] <= data_value_i;
    end
    if (rd_en) vox_rd_q <= vox_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      radius_q   <= RadW'(1);
      sx_q       <= size_t'(DimMax);
      sy_q       <= size_t'(DimMax);
      sz_q       <= size_t'(DimMax);
      scale_q    <= ScaleW'(255);
      ctr_pend_q <= 1'b0;
      dx_q       <= '0;
      dy_q       <= '0;
      dz_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgRadius: radius_q <= cfg_data_i[RadW-1:0];
          CfgSizeX:  sx_q     <= cfg_data_i[SizeW-1:0];
          CfgSizeY:  sy_q     <= cfg_data_i[SizeW-1:0];
          CfgSizeZ:  sz_q     <= cfg_data_i[SizeW-1:0];
          CfgScale:  scale_q  <= cfg_data_i[ScaleW-1:0];
          default: ;
        endcase
      end
      if (state_q == StIdle && state_d == StWalk) begin
        ctr_pend_q <= 1'b1;
        dx_q <= '0;
        dy_q <= '0;
        dz_q <= '0;
      end else if (state_q == StWalk) begin
        if (ctr_pend_q) begin
          ctr_pend_q <= 1'b0;
        end else if (dx_q != r2) begin
          dx_q <= dx_q + 1'b1;
        end else begin
          dx_q <= '0;
          if (dy_q != r2) begin
            dy_q <= dy_q + 1'b1;
          end else begin
            dy_q <= '0;
            dz_q <= dz_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
    end
  end

  vbf_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag_d1_q),
    .vox_i    (vox_rd_q),
    .scale_i  (scale_q),
    .rng_we_i (accept && kind_e'(kind_i) == KindRange),
    .sp_we_i  (accept && kind_e'(kind_i) == KindSpatial
               && weight_index_i < WIdxW'(SpatialEntries)),
    .widx_i   (weight_index_i),
    .wdata_i  (data_value_i),
    .div_o    (div_req)
  );

  vbf_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (quo),
    .zero_o (zero)
  );

  assign busy             = (state_q != StIdle);
  assign result_valid_o   = div_done;
  assign filtered_value_o = quo;
  assign zero_weight_o    = zero;

  a_walk_no_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWalk |-> !accept) else $error("transfer during walk");
  a_result_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv) else $error("stray result");
  a_div_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv && div_done |=> state_q == StIdle) else $error("stuck in div");

endmodule
